### src/baat_pkg.sv
package baat_pkg;

  // One vector component entering the normalizer and one unit component leaving it.
  typedef logic signed [32:0] comp_t;
  typedef logic signed [31:0] unit_t;

  // Register map of the configuration port, by word index.
  typedef enum logic [2:0] {
    REG_AXIS_SELECT = 3'd0,
    REG_FIELD_X     = 3'd1,
    REG_FIELD_Y     = 3'd2,
    REG_FIELD_Z     = 3'd3,
    REG_GAIN        = 3'd4,
    REG_PERIOD      = 3'd5
  } reg_idx_t;

  localparam logic [1:0] AXIS_FIRST  = 2'd0;
  localparam logic [1:0] AXIS_SECOND = 2'd1;

  // Normalizer: three front stages, a root bit per stage, a numerator stage,
  // a quotient bit per stage, and the signed output register.
  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 31;
  localparam int NORM_LAT  = 3 + SQ_STEPS + 1 + DIV_STEPS + 1;

  // Top level stage numbers.
  localparam int MOD_STEPS   = 32;
  localparam int ST_NORM_OUT = 4 + NORM_LAT;
  localparam int SB_DEPTH    = ST_NORM_OUT + 8;

  localparam logic signed [47:0] T_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] T_MIN = 48'sh8000_0000_0000;

  // Per-request control and passthrough data that rides beside the datapath.
  typedef struct packed {
    logic             valid;
    logic             grp;
    logic [31:0]      step;
    logic [15:0]      rem;
    logic             az;
    logic [2:0][47:0] tq;
  } sb_t;

endpackage

### src/baat_norm.sv
module baat_norm (
  input  logic            clk,
  input  baat_pkg::comp_t in_c [3],
  output baat_pkg::unit_t out_u [3],
  output logic            out_zero
);
  import baat_pkg::*;

  logic [31:0] mag1_r [3];
  logic [2:0]  neg1_r;
  logic [63:0] sq2_r [3];
  logic [31:0] mag2_r [3];
  logic [2:0]  neg2_r;

  logic [63:0] sqs_r    [0:SQ_STEPS];
  logic [35:0] sqrem_r  [0:SQ_STEPS];
  logic [31:0] sqroot_r [0:SQ_STEPS];
  logic [31:0] sqmag_r  [0:SQ_STEPS][3];
  logic [2:0]  sqneg_r  [0:SQ_STEPS];
  logic [35:0] sq_sh    [SQ_STEPS];
  logic [35:0] sq_try   [SQ_STEPS];
  logic [35:0] rem_nxt  [SQ_STEPS];
  logic [31:0] root_nxt [SQ_STEPS];

  logic [61:0] dv_num0  [3];
  logic [30:0] dvnum_r  [0:DIV_STEPS][3];
  logic [31:0] dvrem_r  [0:DIV_STEPS][3];
  logic [30:0] dvq_r    [0:DIV_STEPS][3];
  logic [31:0] dvn_r    [0:DIV_STEPS];
  logic [2:0]  dvneg_r  [0:DIV_STEPS];
  logic        dvzero_r [0:DIV_STEPS];
  logic [32:0] dv_t     [DIV_STEPS][3];
  logic [31:0] dvrem_nxt [DIV_STEPS][3];
  logic [30:0] dvq_nxt   [DIV_STEPS][3];

  unit_t out_u_r [3];
  logic  out_zero_r;

  always_comb begin
    for (int j = 0; j < SQ_STEPS; j++) begin
      sq_sh[j]  = {sqrem_r[j][33:0], sqs_r[j][63-2*j -: 2]};
      sq_try[j] = {2'b00, sqroot_r[j], 2'b01};
      if (sq_sh[j] >= sq_try[j]) begin
        rem_nxt[j]  = sq_sh[j] - sq_try[j];
        root_nxt[j] = {sqroot_r[j][30:0], 1'b1};
      end else begin
        rem_nxt[j]  = sq_sh[j];
        root_nxt[j] = {sqroot_r[j][30:0], 1'b0};
      end
    end
  end

  // Rounded quotient: (mag * 2^30 + floor(n / 2)) / n.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_num0[i] = {sqmag_r[SQ_STEPS][i], 30'b0} + 62'(sqroot_r[SQ_STEPS][31:1]);
    end
  end

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      for (int i = 0; i < 3; i++) begin
        dv_t[k][i] = {dvrem_r[k][i], dvnum_r[k][i][DIV_STEPS-1-k]};
        if (dv_t[k][i] >= {1'b0, dvn_r[k]}) begin
          dvrem_nxt[k][i] = 32'(dv_t[k][i] - {1'b0, dvn_r[k]});
          dvq_nxt[k][i]   = {dvq_r[k][i][29:0], 1'b1};
        end else begin
          dvrem_nxt[k][i] = dv_t[k][i][31:0];
          dvq_nxt[k][i]   = {dvq_r[k][i][29:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      neg1_r[i] <= in_c[i][32];
      mag1_r[i] <= in_c[i][32] ? 32'(-in_c[i]) : in_c[i][31:0];
      sq2_r[i]  <= 64'(mag1_r[i]) * 64'(mag1_r[i]);
      mag2_r[i] <= mag1_r[i];
    end
    neg2_r <= neg1_r;

    sqs_r[0]    <= sq2_r[0] + sq2_r[1] + sq2_r[2];
    sqrem_r[0]  <= '0;
    sqroot_r[0] <= '0;
    sqmag_r[0]  <= mag2_r;
    sqneg_r[0]  <= neg2_r;
    for (int j = 0; j < SQ_STEPS; j++) begin
      sqs_r[j+1]    <= sqs_r[j];
      sqrem_r[j+1]  <= rem_nxt[j];
      sqroot_r[j+1] <= root_nxt[j];
      sqmag_r[j+1]  <= sqmag_r[j];
      sqneg_r[j+1]  <= sqneg_r[j];
    end

    // The first remainder is the numerator above the quotient bits; it is
    // always below n because the quotient fits in 31 bits.
    for (int i = 0; i < 3; i++) begin
      dvnum_r[0][i] <= dv_num0[i][30:0];
      dvrem_r[0][i] <= {1'b0, dv_num0[i][61:31]};
      dvq_r[0][i]   <= '0;
    end
    dvn_r[0]    <= sqroot_r[SQ_STEPS];
    dvneg_r[0]  <= sqneg_r[SQ_STEPS];
    dvzero_r[0] <= (sqs_r[SQ_STEPS] == 64'd0);
    for (int k = 0; k < DIV_STEPS; k++) begin
      dvnum_r[k+1]  <= dvnum_r[k];
      dvrem_r[k+1]  <= dvrem_nxt[k];
      dvq_r[k+1]    <= dvq_nxt[k];
      dvn_r[k+1]    <= dvn_r[k];
      dvneg_r[k+1]  <= dvneg_r[k];
      dvzero_r[k+1] <= dvzero_r[k];
    end

    for (int i = 0; i < 3; i++) begin
      out_u_r[i] <= dvneg_r[DIV_STEPS][i] ? -$signed({1'b0, dvq_r[DIV_STEPS][i]})
                                          :  $signed({1'b0, dvq_r[DIV_STEPS][i]});
    end
    out_zero_r <= dvzero_r[DIV_STEPS];
  end

  assign out_u    = out_u_r;
  assign out_zero = out_zero_r;

endmodule

### src/body_axis_alignment_torque_core.sv
// A result strobes on out_valid once its request has run the sideband line sb_r and the output register.
// Throughput: one request per cycle; busy stays low and the pipeline never stalls.
// The depth of the line is set mostly by the two normalizers: a root bit and a quotient bit per stage.
// Reset (rst_n low, synchronous) clears all valid bits and loads the register defaults.
// The receiver cannot stall: each result is on the out_ ports for one cycle only.
module body_axis_alignment_torque_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        in_step_number,
  input  logic               in_in_group,
  input  logic signed [31:0] in_quat_w,
  input  logic signed [31:0] in_quat_x,
  input  logic signed [31:0] in_quat_y,
  input  logic signed [31:0] in_quat_z,
  input  logic signed [47:0] in_torque_in_x,
  input  logic signed [47:0] in_torque_in_y,
  input  logic signed [47:0] in_torque_in_z,
  output logic               out_valid,
  output logic signed [47:0] out_torque_x,
  output logic signed [47:0] out_torque_y,
  output logic signed [47:0] out_torque_z,
  output logic               out_applied,
  output logic               out_degenerate,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import baat_pkg::*;

  localparam int P_WW = 0, P_XX = 1, P_YY = 2, P_ZZ = 3, P_WX = 4;
  localparam int P_WY = 5, P_WZ = 6, P_XY = 7, P_XZ = 8, P_YZ = 9;

  // Configuration registers.
  logic [1:0]         axis_sel_r;
  logic signed [31:0] field_r [3];
  logic signed [31:0] gain_r;
  logic [15:0]        period_r;
  logic [15:0]        per;
  logic               fz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_sel_r <= 2'd2;
      field_r[0] <= 32'sd0;
      field_r[1] <= 32'sd0;
      field_r[2] <= 32'sd65536;
      gain_r     <= 32'sd0;
      period_r   <= 16'd1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_AXIS_SELECT: axis_sel_r <= pwdata[1:0];
        REG_FIELD_X:     field_r[0] <= pwdata;
        REG_FIELD_Y:     field_r[1] <= pwdata;
        REG_FIELD_Z:     field_r[2] <= pwdata;
        REG_GAIN:        gain_r     <= pwdata;
        REG_PERIOD:      period_r   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_AXIS_SELECT: prdata = {30'b0, axis_sel_r};
      REG_FIELD_X:     prdata = field_r[0];
      REG_FIELD_Y:     prdata = field_r[1];
      REG_FIELD_Z:     prdata = field_r[2];
      REG_GAIN:        prdata = gain_r;
      REG_PERIOD:      prdata = {16'b0, period_r};
      default:         prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign per    = (period_r == 16'd0) ? 16'd1 : period_r;
  assign fz     = (field_r[0] == 32'sd0) && (field_r[1] == 32'sd0) && (field_r[2] == 32'sd0);

  // Sideband line: carries the request's control and torque, and works out
  // step_number modulo the period one bit per stage along the way.
  sb_t         sb_r   [1:SB_DEPTH];
  sb_t         sb_nxt [1:SB_DEPTH];
  logic [16:0] md_t   [MOD_STEPS];
  logic        ax_zero;

  always_comb begin
    sb_nxt[1].valid = start && !busy;
    sb_nxt[1].grp   = in_in_group;
    sb_nxt[1].step  = in_step_number;
    sb_nxt[1].rem   = '0;
    sb_nxt[1].az    = 1'b0;
    sb_nxt[1].tq    = {in_torque_in_z, in_torque_in_y, in_torque_in_x};
    for (int i = 0; i < MOD_STEPS; i++) begin
      md_t[i] = {sb_r[i+1].rem, sb_r[i+1].step[MOD_STEPS-1-i]};
    end
    for (int k = 2; k <= SB_DEPTH; k++) begin
      sb_nxt[k] = sb_r[k-1];
      if (k <= MOD_STEPS + 1) begin
        if (md_t[k-2] >= {1'b0, per}) begin
          sb_nxt[k].rem = 16'(md_t[k-2] - {1'b0, per});
        end else begin
          sb_nxt[k].rem = md_t[k-2][15:0];
        end
      end
      if (k == ST_NORM_OUT + 1) begin
        sb_nxt[k].az = ax_zero;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= SB_DEPTH; k++) begin
        sb_r[k].valid <= 1'b0;
      end
    end else begin
      for (int k = 1; k <= SB_DEPTH; k++) begin
        sb_r[k] <= sb_nxt[k];
      end
    end
  end

  // Front end: quaternion products, rounding to Q26, body axis.
  logic signed [31:0] q1_r [4];
  logic signed [63:0] p2_r [10];
  logic signed [29:0] p3_r [10];
  logic signed [63:0] rnd3 [10];
  logic signed [31:0] e4   [10];
  logic signed [31:0] a_nxt [3];
  logic signed [31:0] a4_r  [3];

  always_comb begin
    for (int i = 0; i < 10; i++) begin
      rnd3[i] = p2_r[i] + 64'sd8589934592;
      e4[i]   = 32'(p3_r[i]);
    end
    unique case (axis_sel_r)
      AXIS_FIRST: begin
        a_nxt[0] = e4[P_WW] + e4[P_XX] - e4[P_YY] - e4[P_ZZ];
        a_nxt[1] = (e4[P_WZ] + e4[P_XY]) <<< 1;
        a_nxt[2] = (e4[P_XZ] - e4[P_WY]) <<< 1;
      end
      AXIS_SECOND: begin
        a_nxt[0] = (e4[P_XY] - e4[P_WZ]) <<< 1;
        a_nxt[1] = e4[P_WW] - e4[P_XX] + e4[P_YY] - e4[P_ZZ];
        a_nxt[2] = (e4[P_WX] + e4[P_YZ]) <<< 1;
      end
      default: begin
        a_nxt[0] = (e4[P_WY] + e4[P_XZ]) <<< 1;
        a_nxt[1] = (e4[P_YZ] - e4[P_WX]) <<< 1;
        a_nxt[2] = e4[P_WW] - e4[P_XX] - e4[P_YY] + e4[P_ZZ];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    q1_r[0] <= in_quat_w;
    q1_r[1] <= in_quat_x;
    q1_r[2] <= in_quat_y;
    q1_r[3] <= in_quat_z;
    p2_r[P_WW] <= 64'(q1_r[0]) * 64'(q1_r[0]);
    p2_r[P_XX] <= 64'(q1_r[1]) * 64'(q1_r[1]);
    p2_r[P_YY] <= 64'(q1_r[2]) * 64'(q1_r[2]);
    p2_r[P_ZZ] <= 64'(q1_r[3]) * 64'(q1_r[3]);
    p2_r[P_WX] <= 64'(q1_r[0]) * 64'(q1_r[1]);
    p2_r[P_WY] <= 64'(q1_r[0]) * 64'(q1_r[2]);
    p2_r[P_WZ] <= 64'(q1_r[0]) * 64'(q1_r[3]);
    p2_r[P_XY] <= 64'(q1_r[1]) * 64'(q1_r[2]);
    p2_r[P_XZ] <= 64'(q1_r[1]) * 64'(q1_r[3]);
    p2_r[P_YZ] <= 64'(q1_r[2]) * 64'(q1_r[3]);
    for (int i = 0; i < 10; i++) begin
      p3_r[i] <= rnd3[i][63:34];
    end
    a4_r <= a_nxt;
  end

  // Axis and field are normalized side by side; the field's unit vector only
  // changes sign after the half-space test.
  comp_t ax_in [3];
  comp_t fd_in [3];
  unit_t ua [3];
  unit_t uf [3];
  logic  fd_zero;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ax_in[i] = 33'(a4_r[i]);
      fd_in[i] = 33'(field_r[i]);
    end
  end

  baat_norm u_norm_axis (
    .clk      (clk),
    .in_c     (ax_in),
    .out_u    (ua),
    .out_zero (ax_zero)
  );

  baat_norm u_norm_field (
    .clk      (clk),
    .in_c     (fd_in),
    .out_u    (uf),
    .out_zero (fd_zero)
  );

  // Back end: dot product sign, cross product, gain, saturating add.
  unit_t              ua73_r [3];
  unit_t              uf73_r [3];
  logic signed [63:0] dp73_r [3];
  unit_t              ua74_r [3];
  unit_t              uf74_r [3];
  logic               neg74_r;
  logic signed [63:0] dot74;
  unit_t              ua75_r [3];
  unit_t              uf75_r [3];
  logic signed [63:0] xp76_r [6];
  logic signed [63:0] xd77_r [3];
  logic signed [63:0] cr_sum [3];
  logic signed [32:0] cr78_r [3];
  logic signed [64:0] kp79_r [3];
  logic signed [64:0] kp_sum [3];
  logic signed [41:0] dl80_r [3];

  assign dot74 = dp73_r[0] + dp73_r[1] + dp73_r[2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr_sum[i] = xd77_r[i] + 64'sd536870912;
      kp_sum[i] = kp79_r[i] + 65'sd2097152;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ua73_r[i] <= ua[i];
      uf73_r[i] <= uf[i];
      dp73_r[i] <= 64'(field_r[i]) * 64'(ua[i]);
      ua74_r[i] <= ua73_r[i];
      uf74_r[i] <= uf73_r[i];
      ua75_r[i] <= ua74_r[i];
      uf75_r[i] <= neg74_r ? -uf74_r[i] : uf74_r[i];
    end
    // A dot product of zero counts as pointing away from the axis.
    neg74_r <= dot74[63] || (dot74 == 64'sd0);

    xp76_r[0] <= 64'(ua75_r[1]) * 64'(uf75_r[2]);
    xp76_r[1] <= 64'(ua75_r[2]) * 64'(uf75_r[1]);
    xp76_r[2] <= 64'(ua75_r[2]) * 64'(uf75_r[0]);
    xp76_r[3] <= 64'(ua75_r[0]) * 64'(uf75_r[2]);
    xp76_r[4] <= 64'(ua75_r[0]) * 64'(uf75_r[1]);
    xp76_r[5] <= 64'(ua75_r[1]) * 64'(uf75_r[0]);
    for (int i = 0; i < 3; i++) begin
      xd77_r[i] <= xp76_r[2*i] - xp76_r[2*i+1];
      cr78_r[i] <= cr_sum[i][62:30];
      kp79_r[i] <= 65'(gain_r) * 65'(cr78_r[i]);
      dl80_r[i] <= kp_sum[i][63:22];
    end
  end

  logic               act;
  logic               dg;
  logic               ap;
  logic signed [48:0] v [3];
  logic signed [47:0] sat [3];
  logic signed [47:0] tin [3];

  always_comb begin
    act = sb_r[SB_DEPTH].grp && (sb_r[SB_DEPTH].rem == 16'd0);
    dg  = act && (sb_r[SB_DEPTH].az || fz || fd_zero);
    ap  = act && !dg;
    for (int i = 0; i < 3; i++) begin
      tin[i] = $signed(sb_r[SB_DEPTH].tq[i]);
      v[i]   = 49'(tin[i]) + 49'(dl80_r[i]);
      if (v[i][48] != v[i][47]) begin
        sat[i] = v[i][48] ? T_MIN : T_MAX;
      end else begin
        sat[i] = v[i][47:0];
      end
    end
  end

  logic               out_valid_r;
  logic signed [47:0] out_tq_r [3];
  logic               out_applied_r;
  logic               out_degenerate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sb_r[SB_DEPTH].valid;
    end
    for (int i = 0; i < 3; i++) begin
      out_tq_r[i] <= ap ? sat[i] : tin[i];
    end
    out_applied_r    <= ap;
    out_degenerate_r <= dg;
  end

  assign out_valid      = out_valid_r;
  assign out_torque_x   = out_tq_r[0];
  assign out_torque_y   = out_tq_r[1];
  assign out_torque_z   = out_tq_r[2];
  assign out_applied    = out_applied_r;
  assign out_degenerate = out_degenerate_r;

`ifndef SYNTHESIS
  a_out_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, SB_DEPTH + 1))
    else $error("result strobe without a matching request");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_applied && out_degenerate))
    else $error("applied and degenerate set together");

  a_applied_needs_field: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_applied) |-> !fz)
    else $error("torque applied with a zero field");
`endif

endmodule
